FILE: src/mphr_pkg.sv
// Shared types and constants for the multichannel peak-hold reporter.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps

package mphr_pkg;

  localparam int CHANNELS = 16;
  localparam int IDX_W    = $clog2(CHANNELS);
  localparam int VAL_W    = 10;
  localparam int ADDR_W   = 8;
  localparam int CH_SHIFT = 10;
  localparam int WORD_W   = 16;

  localparam logic [7:0]       END_MARKER     = 8'h7F;
  localparam logic [VAL_W-1:0] THRESHOLD_INIT = VAL_W'(4);
  localparam logic [7:0]       ADDRESS_INIT   = 8'h31;

  typedef enum logic {
    REG_PEAK_THRESHOLD = 1'b0,
    REG_OWN_ADDRESS    = 1'b1
  } mphr_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SEND_LO,
    ST_SEND_HI,
    ST_SEND_END
  } mphr_state_t;

  // controller -> datapath
  typedef struct packed {
    logic upd_peak;   // apply accepted sample
    logic idx_clr;    // start of report walk
    logic idx_inc;    // move to next channel
    logic scan_wr;    // visit channel: capture word, record and clear peak
    logic load_lo;
    logic load_hi;
    logic load_end;
  } mphr_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_sample;
    logic is_poll;
    logic differs;
    logic idx_last;
    logic out_free;
  } mphr_status_t;

endpackage

FILE: src/multichannel_peak_hold_reporter.sv
// Top level of the multichannel peak-hold reporter.
// Depends on mphr_pkg, mphr_ctrl and mphr_datapath.
`timescale 1ns / 1ps

// Keeps a peak-hold value for each of 16 channels and reports the changed
// ones when polled. A sample word (command = 0) raises its channel's peak
// when the sample is at or above peak_threshold and above the held peak; it
// produces no output. A serial word (command = 1)
// equal to own_address starts a report; any other serial word is dropped.
// The report walks channels 0..15 in order through the single read port of
// the channel tables, and a channel whose peak differs from its last
// reported value adds two output words, low then high byte of
// (channel << 10) | peak. Every visited channel has its peak recorded as
// reported and cleared. The report closes with 0x7F, ninth_bit and last set.
// The next input word is taken as soon as the end marker sits in the output
// register. Config writes go straight to the registers (index 0 threshold,
// index 1 address) and are expected only while no report is running.

module multichannel_peak_hold_reporter import mphr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  // configuration
  input  logic             cfg_write,
  input  logic             cfg_index,
  input  logic [VAL_W-1:0] cfg_data,
  // input words
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             command,
  input  logic [3:0]       channel,
  input  logic [VAL_W-1:0] sample,
  input  logic [7:0]       rx_byte,
  // output words
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       tx_byte,
  output logic             ninth_bit,
  output logic             last
);

  mphr_cmd_t    cmd;
  mphr_status_t status;

  mphr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  mphr_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .command   (command),
    .channel   (channel),
    .sample    (sample),
    .rx_byte   (rx_byte),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .tx_byte   (tx_byte),
    .ninth_bit (ninth_bit),
    .last      (last),
    .cmd       (cmd),
    .status    (status)
  );

  // only one output load at a time
  a_one_load: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load_lo, cmd.load_hi, cmd.load_end}))
    else $error("multiple output loads");

  // end marker load shows up as a valid closing word
  a_end_word: assert property (@(posedge clk) disable iff (rst)
    cmd.load_end |=> (out_valid && last && ninth_bit && tx_byte == END_MARKER))
    else $error("end marker not presented");

  // peak updates only happen on an accepted sample
  a_upd_on_accept: assert property (@(posedge clk) disable iff (rst)
    cmd.upd_peak |-> (in_valid && in_ready && !command))
    else $error("peak update without accepted sample");

  // table walk never overlaps input acceptance
  a_no_scan_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_wr |-> !in_ready)
    else $error("scan while accepting input");

endmodule

FILE: src/mphr_ctrl.sv
// Report sequencer for the peak-hold reporter.
// Depends on mphr_pkg (state, command and status types).
`timescale 1ns / 1ps

module mphr_ctrl import mphr_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  mphr_status_t status,
  output mphr_cmd_t    cmd
);

  mphr_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && status.is_poll) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (status.differs)       state_next = ST_SEND_LO;
        else if (status.idx_last) state_next = ST_SEND_END;
      end
      ST_SEND_LO: begin
        if (status.out_free) state_next = ST_SEND_HI;
      end
      ST_SEND_HI: begin
        if (status.out_free) state_next = status.idx_last ? ST_SEND_END : ST_SCAN;
      end
      ST_SEND_END: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready     = 1'b1;
        cmd.upd_peak = in_valid && status.is_sample;
        cmd.idx_clr  = in_valid && status.is_poll;
      end
      ST_SCAN: begin
        cmd.scan_wr = 1'b1;
        cmd.idx_inc = !status.differs && !status.idx_last;
      end
      ST_SEND_LO: begin
        cmd.load_lo = status.out_free;
      end
      ST_SEND_HI: begin
        cmd.load_hi = status.out_free;
        cmd.idx_inc = status.out_free && !status.idx_last;
      end
      ST_SEND_END: begin
        cmd.load_end = status.out_free;
      end
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

FILE: src/mphr_datapath.sv
// Peak/reported tables, config registers, channel index and output word register.
// Depends on mphr_pkg (constants, command and status types).
`timescale 1ns / 1ps

module mphr_datapath import mphr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic             cfg_index,
  input  logic [VAL_W-1:0] cfg_data,
  input  logic             command,
  input  logic [3:0]       channel,
  input  logic [VAL_W-1:0] sample,
  input  logic [7:0]       rx_byte,
  input  logic             out_ready,
  output logic             out_valid,
  output logic [7:0]       tx_byte,
  output logic             ninth_bit,
  output logic             last,
  input  mphr_cmd_t        cmd,
  output mphr_status_t     status
);

  logic [VAL_W-1:0]  peak_threshold;
  logic [ADDR_W-1:0] own_address;
  logic [VAL_W-1:0]  peak_value     [CHANNELS];
  logic [VAL_W-1:0]  reported_value [CHANNELS];
  logic [IDX_W-1:0]  idx;
  logic [WORD_W-1:0] word;

  logic [IDX_W-1:0]  chan_idx;
  logic [IDX_W-1:0]  rd_addr;
  logic [VAL_W-1:0]  peak_rd;
  logic [VAL_W-1:0]  rep_rd;
  logic              chan_ok;
  logic              sample_wins;

  always_ff @(posedge clk) begin
    if (rst) begin
      peak_threshold <= THRESHOLD_INIT;
      own_address    <= ADDRESS_INIT;
    end else if (cfg_write) begin
      case (mphr_reg_t'(cfg_index))
        REG_PEAK_THRESHOLD: peak_threshold <= cfg_data;
        REG_OWN_ADDRESS:    own_address    <= cfg_data[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  assign chan_idx = IDX_W'(channel);
  assign chan_ok  = 32'(channel) < CHANNELS;
  // one read port: scan index while walking, sample channel otherwise
  assign rd_addr  = cmd.scan_wr ? idx : chan_idx;
  assign peak_rd  = peak_value[rd_addr];
  assign rep_rd   = reported_value[rd_addr];

  assign sample_wins = chan_ok && (sample > peak_rd) && (sample >= peak_threshold);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        peak_value[i]     <= '0;
        reported_value[i] <= '0;
      end
    end else if (cmd.scan_wr) begin
      reported_value[idx] <= peak_rd;
      peak_value[idx]     <= '0;
    end else if (cmd.upd_peak && sample_wins) begin
      peak_value[chan_idx] <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + 1'b1;
    end
  end

  // (channel << 10) | peak, channel bits above bit 15 dropped
  always_ff @(posedge clk) begin
    if (cmd.scan_wr) begin
      word <= WORD_W'((32'(idx) << CH_SHIFT) | 32'(peak_rd));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_lo || cmd.load_hi || cmd.load_end) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_lo) begin
      tx_byte   <= word[7:0];
      ninth_bit <= 1'b0;
      last      <= 1'b0;
    end else if (cmd.load_hi) begin
      tx_byte   <= word[15:8];
      ninth_bit <= 1'b0;
      last      <= 1'b0;
    end else if (cmd.load_end) begin
      tx_byte   <= END_MARKER;
      ninth_bit <= 1'b1;
      last      <= 1'b1;
    end
  end

  assign status.is_sample = !command;
  assign status.is_poll   = command && (rx_byte == own_address);
  assign status.differs   = peak_rd != rep_rd;
  assign status.idx_last  = idx == IDX_W'(CHANNELS - 1);
  assign status.out_free  = !out_valid || out_ready;

endmodule
